FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition must never hold
`define AST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

FILE: rtl/ffa_pkg.sv
package ffa_pkg;

  // segment cell operations, broadcast to the whole row
  typedef enum logic [2:0] {
    SEG_HOLD,
    SEG_INIT,
    SEG_CARVE,
    SEG_REMOVE,
    SEG_MERGE_BOTH,
    SEG_MERGE_PREV,
    SEG_MERGE_NEXT,
    SEG_INSERT
  } seg_op_e;

  // per-cell status toward the controller
  typedef struct packed {
    logic exact;
    logic join_prev;
    logic join_next;
  } ffa_cell_stat_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] REG_HEAP_SIZE = 2'd0;
  localparam logic [1:0] REG_HEADER    = 2'd1;

  localparam int unsigned REQ_W   = 16;
  localparam int unsigned OADDR_W = 16;
  localparam int unsigned HEAP_W  = 17;
  localparam int unsigned HDR_W   = 7;

  localparam logic [HEAP_W-1:0] HEAP_RESET   = 17'd1024;
  localparam logic [HDR_W-1:0]  HEADER_RESET = 7'd8;

endpackage

FILE: rtl/ffa_cell.sv
module ffa_cell import ffa_pkg::*; #(
  parameter int unsigned AW      = 16,
  parameter bit          IS_HEAD = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  seg_op_e        op_i,
  input  logic [((AW+2 > 18) ? AW+2 : 18)-1:0] total_i,
  input  logic [AW-1:0]  bs_i,
  input  logic [AW:0]    bl_i,
  input  logic [AW:0]    init_len_i,
  input  logic           prev_valid_i,
  input  logic [AW-1:0]  prev_start_i,
  input  logic [AW:0]    prev_len_i,
  input  logic           next_valid_i,
  input  logic [AW-1:0]  next_start_i,
  input  logic [AW:0]    next_len_i,
  input  logic           fit_in_i,
  output logic           fit_out_o,
  input  logic           pos_in_i,
  output logic           pos_out_o,
  input  logic           next_is_pos_i,
  output logic           is_pos_o,
  output logic           valid_o,
  output logic [AW-1:0]  start_o,
  output logic [AW:0]    len_o,
  output logic [AW-1:0]  hit_start_o,
  output ffa_cell_stat_t stat_o
);

  localparam int unsigned CW = (AW+2 > 18) ? AW+2 : 18;
  localparam logic [AW:0]    LIMIT   = {1'b1, {AW{1'b0}}};
  localparam logic [CW-1:0]  RST_W   = CW'(HEAP_RESET);
  localparam logic [AW:0]    RST_LEN = (RST_W > CW'(LIMIT)) ? LIMIT : (AW+1)'(RST_W);

  logic          valid_q, valid_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW:0]   len_q, len_d;
  logic          hit_q, at_hit_q, pos_q, at_pos_q, pnext_q;

  logic cand_fit, fit_first, cand_pos, pos_first, end_eq, start_eq;

  assign cand_fit  = valid_q && (CW'(len_q) >= total_i);
  assign fit_first = cand_fit && !fit_in_i;
  assign fit_out_o = fit_in_i || cand_fit;

  assign cand_pos  = !valid_q || (start_q >= bs_i);
  assign pos_first = cand_pos && !pos_in_i;
  assign pos_out_o = pos_in_i || cand_pos;
  assign is_pos_o  = pos_first;

  assign end_eq   = ((AW+1)'(start_q) + len_q) == (AW+1)'(bs_i);
  assign start_eq = (AW+1)'(start_q) == ((AW+1)'(bs_i) + bl_i);

  assign stat_o.exact     = fit_first && (CW'(len_q) == total_i);
  assign stat_o.join_prev = next_is_pos_i && valid_q && end_eq;
  assign stat_o.join_next = pos_first && valid_q && start_eq;

  assign hit_start_o = fit_first ? start_q : '0;
  assign valid_o     = valid_q;
  assign start_o     = start_q;
  assign len_o       = len_q;

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    case (op_i)
      SEG_INIT: begin
        valid_d = IS_HEAD && (init_len_i != '0);
        start_d = '0;
        len_d   = IS_HEAD ? init_len_i : '0;
      end
      SEG_CARVE: begin
        if (hit_q) begin
          start_d = AW'(CW'(start_q) + total_i);
          len_d   = (AW+1)'(CW'(len_q) - total_i);
        end
      end
      SEG_REMOVE: begin
        if (at_hit_q) begin
          valid_d = next_valid_i;
          start_d = next_start_i;
          len_d   = next_len_i;
        end
      end
      SEG_MERGE_BOTH: begin
        if (pnext_q) begin
          len_d = len_q + bl_i + next_len_i;
        end else if (at_pos_q) begin
          valid_d = next_valid_i;
          start_d = next_start_i;
          len_d   = next_len_i;
        end
      end
      SEG_MERGE_PREV: begin
        if (pnext_q) len_d = len_q + bl_i;
      end
      SEG_MERGE_NEXT: begin
        if (pos_q) begin
          start_d = bs_i;
          len_d   = len_q + bl_i;
        end
      end
      SEG_INSERT: begin
        if (pos_q) begin
          valid_d = 1'b1;
          start_d = bs_i;
          len_d   = bl_i;
        end else if (at_pos_q) begin
          valid_d = prev_valid_i;
          start_d = prev_start_i;
          len_d   = prev_len_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= IS_HEAD;
      start_q <= '0;
      len_q   <= IS_HEAD ? RST_LEN : '0;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  // position flags, taken during planning and used on the apply cycle
  always_ff @(posedge clk_i) begin
    hit_q    <= fit_first;
    at_hit_q <= fit_out_o;
    pos_q    <= pos_first;
    at_pos_q <= pos_out_o;
    pnext_q  <= next_is_pos_i;
  end

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// Channel   Direction  Handshake                      Payload
// command   in         start && !busy                 cmd_i, request_size_i, block_address_i
// result    out        result_valid_o (one cycle)     status_o, result_address_o
// config    in         cfg_valid_i && cfg_ready_o     cfg_index_i, cfg_data_i
//
// After the accept edge the item passes an alignment step (rounded-up quotient by
// reciprocal multiplication), then live lookup, live read, segment plan and
// segment apply; the strobe comes the cycle after apply. A new item can be
// accepted at the edge that ends the strobe cycle, not before the last item is
// done. The segment row updates all cells in the apply cycle. Reset is
// asynchronous and leaves one free segment of 1024 bytes and no live blocks, with
// no clearing pass. The receiver cannot stall; busy is high from accept until apply
// completes.
`include "assert_macros.svh"

module first_fit_heap_allocator import ffa_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned MAX_LIVE     = 16,
  parameter int unsigned ALIGN_BYTES  = 8,
  parameter int unsigned ADDR_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [REQ_W-1:0]   request_size_i,
  input  logic [REQ_W-1:0]   block_address_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic [OADDR_W-1:0] result_address_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [HEAP_W-1:0]  cfg_data_i
);

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned CW  = (AW+2 > 18) ? AW+2 : 18;
  localparam int unsigned LIW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  // reciprocal for floor(x / ALIGN_BYTES), exact for every x below 2^QN
  localparam int unsigned QN  = REQ_W + 1;
  localparam int unsigned QS  = QN + $clog2(ALIGN_BYTES);
  localparam int unsigned MW  = QN + 1;
  localparam int unsigned PW  = QN + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << QS) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [AW:0]   LIMIT = {1'b1, {AW{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_ALIGN, S_LOOK, S_READ, S_PLAN, S_APPLY} state_e;

  state_e              state_q;
  logic                cmd_q;
  logic [REQ_W-1:0]    req_q, baddr_q;
  logic [QN-1:0]       quo_q;
  logic [CW-1:0]       total_q;
  logic [LIW-1:0]      free_slot_q, match_q;
  logic                free_any_q, match_any_q;
  logic [AW-1:0]       bs_q, plan_start_q;
  logic [AW:0]         bl_q;
  seg_op_e             plan_op_q;
  logic [2:0]          plan_st_q;
  logic                plan_ok_q;
  logic [OADDR_W-1:0]  plan_addr_q;
  logic [HDR_W-1:0]    header_q;
  logic                out_valid_q;
  logic [2:0]          out_st_q;
  logic [OADDR_W-1:0]  out_addr_q;

  // live allocation table
  logic [AW-1:0]       live_start_q [MAX_LIVE];
  logic [AW:0]         live_len_q   [MAX_LIVE];
  logic [MAX_LIVE-1:0] live_valid_q;

  logic heap_wr, hdr_wr;
  assign cfg_ready_o = 1'b1;
  assign heap_wr = cfg_valid_i && (cfg_index_i == REG_HEAP_SIZE);
  assign hdr_wr  = cfg_valid_i && (cfg_index_i == REG_HEADER);
  assign busy    = (state_q != S_IDLE);

  // heap size clamped to the address space
  logic [CW-1:0] hs_w;
  logic [AW:0]   init_len;
  assign hs_w     = CW'(cfg_data_i);
  assign init_len = (hs_w > CW'(LIMIT)) ? LIMIT : (AW+1)'(hs_w);

  // rounded-up quotient: (req + align - 1) / align by reciprocal multiply
  logic [QN-1:0] round_up;
  logic [PW-1:0] quo_prod;
  logic [QN-1:0] quo_d;
  assign round_up = QN'(req_q) + QN'(ALIGN_BYTES - 1);
  assign quo_prod = PW'(round_up) * PW'(RECIP);
  assign quo_d    = QN'(quo_prod >> QS);

  logic [CW-1:0] total_d;
  assign total_d = CW'(quo_q) * CW'(ALIGN_BYTES) + CW'(header_q);

  // live lookup: first empty slot and matching user address
  logic           f_found, m_found;
  logic [LIW-1:0] f_idx, m_idx;
  always_comb begin
    f_found = 1'b0;
    m_found = 1'b0;
    f_idx   = '0;
    m_idx   = '0;
    for (int i = 0; i < MAX_LIVE; i++) begin
      if (!f_found && !live_valid_q[i]) begin
        f_found = 1'b1;
        f_idx   = LIW'(i);
      end
      if (!m_found && live_valid_q[i] &&
          ((CW'(live_start_q[i]) + CW'(header_q)) == CW'(baddr_q))) begin
        m_found = 1'b1;
        m_idx   = LIW'(i);
      end
    end
  end

  // segment row
  seg_op_e                 seg_op;
  logic [MAX_SEGMENTS:0]   fit_ch, pos_ch;
  logic [MAX_SEGMENTS-1:0] c_valid, c_is_pos, nb_next_is_pos;
  logic [AW-1:0]           c_start [MAX_SEGMENTS];
  logic [AW:0]             c_len   [MAX_SEGMENTS];
  logic [AW-1:0]           c_hit   [MAX_SEGMENTS];
  ffa_cell_stat_t          c_stat  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] nb_pv, nb_nv;
  logic [AW-1:0]           nb_ps [MAX_SEGMENTS];
  logic [AW-1:0]           nb_ns [MAX_SEGMENTS];
  logic [AW:0]             nb_pl [MAX_SEGMENTS];
  logic [AW:0]             nb_nl [MAX_SEGMENTS];

  assign seg_op    = heap_wr ? SEG_INIT : ((state_q == S_APPLY) ? plan_op_q : SEG_HOLD);
  assign fit_ch[0] = 1'b0;
  assign pos_ch[0] = 1'b0;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign nb_pv[g] = 1'b0;
      assign nb_ps[g] = '0;
      assign nb_pl[g] = '0;
    end else begin : g_mid
      assign nb_pv[g] = c_valid[g-1];
      assign nb_ps[g] = c_start[g-1];
      assign nb_pl[g] = c_len[g-1];
    end
    if (g == MAX_SEGMENTS-1) begin : g_last
      assign nb_nv[g] = 1'b0;
      assign nb_ns[g] = '0;
      assign nb_nl[g] = '0;
      // position just past a full table
      assign nb_next_is_pos[g] = !pos_ch[MAX_SEGMENTS];
    end else begin : g_inner
      assign nb_nv[g] = c_valid[g+1];
      assign nb_ns[g] = c_start[g+1];
      assign nb_nl[g] = c_len[g+1];
      assign nb_next_is_pos[g] = c_is_pos[g+1];
    end

    ffa_cell #(
      .AW      (AW),
      .IS_HEAD (g == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (seg_op),
      .total_i       (total_q),
      .bs_i          (bs_q),
      .bl_i          (bl_q),
      .init_len_i    (init_len),
      .prev_valid_i  (nb_pv[g]),
      .prev_start_i  (nb_ps[g]),
      .prev_len_i    (nb_pl[g]),
      .next_valid_i  (nb_nv[g]),
      .next_start_i  (nb_ns[g]),
      .next_len_i    (nb_nl[g]),
      .fit_in_i      (fit_ch[g]),
      .fit_out_o     (fit_ch[g+1]),
      .pos_in_i      (pos_ch[g]),
      .pos_out_o     (pos_ch[g+1]),
      .next_is_pos_i (nb_next_is_pos[g]),
      .is_pos_o      (c_is_pos[g]),
      .valid_o       (c_valid[g]),
      .start_o       (c_start[g]),
      .len_o         (c_len[g]),
      .hit_start_o   (c_hit[g]),
      .stat_o        (c_stat[g])
    );
  end

  logic          exact_any, jp_any, jn_any, seg_full;
  logic [AW-1:0] hit_start;
  always_comb begin
    exact_any = 1'b0;
    jp_any    = 1'b0;
    jn_any    = 1'b0;
    hit_start = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      exact_any = exact_any | c_stat[k].exact;
      jp_any    = jp_any | c_stat[k].join_prev;
      jn_any    = jn_any | c_stat[k].join_next;
      hit_start = hit_start | c_hit[k];
    end
  end
  assign seg_full = c_valid[MAX_SEGMENTS-1];

  // plan decision
  seg_op_e            pl_op;
  logic [2:0]         pl_st;
  logic               pl_ok;
  always_comb begin
    pl_op = SEG_HOLD;
    pl_st = ST_OK;
    pl_ok = 1'b0;
    if (cmd_q == CMD_ALLOC) begin
      if (req_q == '0) begin
        pl_st = ST_BAD;
      end else if (!free_any_q) begin
        pl_st = ST_FULL;
      end else if (fit_ch[MAX_SEGMENTS]) begin
        pl_ok = 1'b1;
        pl_op = exact_any ? SEG_REMOVE : SEG_CARVE;
      end else begin
        pl_st = ST_NOSPACE;
      end
    end else begin
      if (!match_any_q) begin
        pl_st = (baddr_q == '0) ? ST_BAD : ST_INVALID;
      end else if (!jp_any && !jn_any && seg_full) begin
        pl_st = ST_FULL;
      end else begin
        pl_ok = 1'b1;
        if (jp_any && jn_any) pl_op = SEG_MERGE_BOTH;
        else if (jp_any)      pl_op = SEG_MERGE_PREV;
        else if (jn_any)      pl_op = SEG_MERGE_NEXT;
        else                  pl_op = SEG_INSERT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_ALLOC;
      req_q        <= '0;
      baddr_q      <= '0;
      quo_q        <= '0;
      total_q      <= '0;
      free_slot_q  <= '0;
      free_any_q   <= 1'b0;
      match_q      <= '0;
      match_any_q  <= 1'b0;
      bs_q         <= '0;
      bl_q         <= '0;
      plan_op_q    <= SEG_HOLD;
      plan_st_q    <= ST_OK;
      plan_ok_q    <= 1'b0;
      plan_addr_q  <= '0;
      plan_start_q <= '0;
      header_q     <= HEADER_RESET;
      out_valid_q  <= 1'b0;
      out_st_q     <= ST_OK;
      out_addr_q   <= '0;
    end else begin
      out_valid_q <= 1'b0;
      if (hdr_wr) header_q <= cfg_data_i[HDR_W-1:0];
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            req_q   <= request_size_i;
            baddr_q <= block_address_i;
            state_q <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          quo_q   <= quo_d;
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          total_q     <= total_d;
          free_slot_q <= f_idx;
          free_any_q  <= f_found;
          match_q     <= m_idx;
          match_any_q <= m_found;
          state_q     <= S_READ;
        end
        S_READ: begin
          bs_q    <= live_start_q[match_q];
          bl_q    <= live_len_q[match_q];
          state_q <= S_PLAN;
        end
        S_PLAN: begin
          plan_op_q    <= pl_op;
          plan_st_q    <= pl_st;
          plan_ok_q    <= pl_ok;
          plan_start_q <= hit_start;
          plan_addr_q  <= OADDR_W'(CW'(hit_start) + CW'(header_q));
          state_q      <= S_APPLY;
        end
        S_APPLY: begin
          out_valid_q <= 1'b1;
          out_st_q    <= plan_st_q;
          out_addr_q  <= (plan_ok_q && (cmd_q == CMD_ALLOC)) ? plan_addr_q : '0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic live_wr;
  assign live_wr = (state_q == S_APPLY) && plan_ok_q && (cmd_q == CMD_ALLOC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_valid_q <= '0;
    end else if (heap_wr) begin
      live_valid_q <= '0;
    end else if ((state_q == S_APPLY) && plan_ok_q) begin
      if (cmd_q == CMD_ALLOC) live_valid_q[free_slot_q] <= 1'b1;
      else                    live_valid_q[match_q]     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (live_wr) begin
      live_start_q[free_slot_q] <= plan_start_q;
      live_len_q[free_slot_q]   <= (AW+1)'(total_q);
    end
  end

  assign result_valid_o   = out_valid_q;
  assign status_o         = out_st_q;
  assign result_address_o = out_addr_q;

  // free segments stay packed at the low end of the row
  logic seg_hole;
  always_comb begin
    seg_hole = 1'b0;
    for (int k = 0; k + 1 < MAX_SEGMENTS; k++) begin
      seg_hole = seg_hole | (c_valid[k+1] & ~c_valid[k]);
    end
  end

  `AST_IMP(a_strobe_after_apply, result_valid_o, $past(state_q == S_APPLY))
  `AST_NEXT(a_accept_goes_busy, start && !busy, busy)
  `AST_IMP(a_addr_only_ok, result_valid_o && (result_address_o != '0), status_o == ST_OK)
  `AST_NEVER(a_seg_packed, seg_hole)

endmodule

FILE: sim/first_fit_heap_allocator_test.sv
module first_fit_heap_allocator_test;
  import ffa_pkg::*;

  localparam int unsigned NSEG      = 16;
  localparam int unsigned NLIVE     = 16;
  localparam int unsigned ALIGN     = 8;
  localparam int unsigned DRAIN_CYC = 20;      // margin past the accept-to-strobe path
  localparam int unsigned CYC_LIMIT = 500000;  // timeout for about 1300 items, with a wide margin

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [REQ_W-1:0]   request_size_i;
  logic [REQ_W-1:0]   block_address_i;
  logic               result_valid_o;
  logic [2:0]         status_o;
  logic [OADDR_W-1:0] result_address_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [HEAP_W-1:0]  cfg_data_i;

  first_fit_heap_allocator uut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .request_size_i, .block_address_i,
    .result_valid_o, .status_o, .result_address_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one response item: status plus user address
  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] addr;
  } alloc_reply_t;

  alloc_reply_t pending_replies[$];
  int unsigned  mismatches;
  int unsigned  status_seen[5];
  int unsigned  cycle_cnt;
  bit           idle_on;

  // ---------------------------------------------------------------------------
  // Shadow heap: free segments in address order, live block table, registers
  // ---------------------------------------------------------------------------
  int unsigned heap_bytes;
  int unsigned hdr_bytes;
  int unsigned free_base[NSEG];
  int unsigned free_len[NSEG];
  int unsigned free_cnt;
  int unsigned blk_base[NLIVE];
  int unsigned blk_len[NLIVE];
  bit          blk_live[NLIVE];

  // heap_size write: clamp to 64K, one free segment (none for a zero heap), drop every live block
  function automatic void heap_rebuild(input int unsigned raw);
    heap_bytes = raw & 32'h1FFFF;
    if (heap_bytes > 32'h10000) heap_bytes = 32'h10000;
    for (int i = 0; i < NSEG; i++) begin
      free_base[i] = 0;
      free_len[i]  = 0;
    end
    for (int i = 0; i < NLIVE; i++) blk_live[i] = 1'b0;
    free_cnt = (heap_bytes != 0) ? 1 : 0;
    free_len[0] = heap_bytes;
  endfunction

  function automatic void seg_drop(input int unsigned idx);
    for (int k = idx; k + 1 < free_cnt; k++) begin
      free_base[k] = free_base[k+1];
      free_len[k]  = free_len[k+1];
    end
    free_cnt--;
  endfunction

  function automatic alloc_reply_t heap_alloc(input logic [15:0] req);
    alloc_reply_t r;
    int           slot;
    int unsigned  total;
    int unsigned  base;
    r    = '{st: ST_NOSPACE, addr: '0};
    slot = -1;
    if (req == 0) begin
      r.st = ST_BAD;
      return r;
    end
    for (int i = NLIVE - 1; i >= 0; i--) if (!blk_live[i]) slot = i;
    if (slot < 0) begin
      r.st = ST_FULL;
      return r;
    end
    total = ((int'(req) + ALIGN - 1) / ALIGN) * ALIGN + hdr_bytes;
    for (int i = 0; i < free_cnt; i++) begin
      if (free_len[i] >= total) begin
        base = free_base[i];
        if (free_len[i] == total) seg_drop(i);
        else begin
          free_base[i] += total;
          free_len[i]  -= total;
        end
        blk_base[slot] = base;
        blk_len[slot]  = total;
        blk_live[slot] = 1'b1;
        r.st   = ST_OK;
        r.addr = 16'(base + hdr_bytes);
        return r;
      end
    end
    return r;
  endfunction

  function automatic alloc_reply_t heap_release(input logic [15:0] uaddr);
    alloc_reply_t r;
    int           slot;
    int unsigned  bs, bl, pos;
    bit           jp, jn;
    r    = '{st: ST_OK, addr: '0};
    slot = -1;
    // match on the header size in force now, not at allocation time
    for (int i = NLIVE - 1; i >= 0; i--)
      if (blk_live[i] && blk_base[i] + hdr_bytes == uaddr) slot = i;
    if (slot < 0) begin
      r.st = (uaddr == 0) ? ST_BAD : ST_INVALID;
      return r;
    end
    bs  = blk_base[slot];
    bl  = blk_len[slot];
    pos = 0;
    while (pos < free_cnt && free_base[pos] < bs) pos++;
    jp = pos > 0 && free_base[pos-1] + free_len[pos-1] == bs;
    jn = pos < free_cnt && bs + bl == free_base[pos];
    if (!jp && !jn && free_cnt >= NSEG) begin
      r.st = ST_FULL;   // block stays live
      return r;
    end
    blk_live[slot] = 1'b0;
    if (jp) begin
      free_len[pos-1] += bl;
      if (jn) begin
        free_len[pos-1] += free_len[pos];
        seg_drop(pos);
      end
    end else if (jn) begin
      free_base[pos] = bs;
      free_len[pos] += bl;
    end else begin
      for (int k = free_cnt; k > pos; k--) begin
        free_base[k] = free_base[k-1];
        free_len[k]  = free_len[k-1];
      end
      free_base[pos] = bs;
      free_len[pos]  = bl;
      free_cnt++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Called at a rising-edge step. Leaves start high after the accept so a
  // back-to-back item needs no second assignment in the same step; whoever
  // does not follow with an item lowers it right away.
  task automatic issue(input logic c, input logic [15:0] req, input logic [15:0] uaddr,
                       input bit typed, input alloc_reply_t typed_reply);
    alloc_reply_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start           <= 1'b1;
    cmd_i           <= c;
    request_size_i  <= req;
    block_address_i <= uaddr;
    do @(posedge clk_i); while (busy);
    got = (c == CMD_ALLOC) ? heap_alloc(req) : heap_release(uaddr);
    pending_replies.push_back(typed ? typed_reply : got);
  endtask

  // let everything in flight land, then a margin for the last apply cycle
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= HEAP_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_HEAP_SIZE) heap_rebuild(val);
    else hdr_bytes = val & 32'h7F;
  endtask

  // random item, mostly frees of real blocks and small requests
  task automatic random_item();
    int unsigned  pick;
    int           slot;
    alloc_reply_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) issue(CMD_ALLOC, 16'($urandom_range(1, 96)), 16'($urandom), 0, none);
    else if (pick < 50) issue(CMD_ALLOC, 16'($urandom), 16'($urandom), 0, none);
    else if (pick < 54) issue(CMD_ALLOC, 16'd0, 16'($urandom), 0, none);
    else if (pick < 88) begin
      slot = -1;
      for (int t = 0; t < 8 && slot < 0; t++) begin
        slot = $urandom_range(0, NLIVE - 1);
        if (!blk_live[slot]) slot = -1;
      end
      if (slot >= 0)
        issue(CMD_FREE, 16'($urandom), 16'(blk_base[slot] + hdr_bytes), 0, none);
      else
        issue(CMD_FREE, 16'($urandom), 16'($urandom), 0, none);
    end
    else if (pick < 92) issue(CMD_FREE, 16'($urandom), 16'd0, 0, none);
    else issue(CMD_FREE, 16'($urandom), 16'($urandom), 0, none);
  endtask

  // directed rows; typed replies only where obvious from the reset heap
  typedef struct {
    logic         c;
    logic [15:0]  req;
    logic [15:0]  uaddr;
    int unsigned  reps;
    bit           typed;
    alloc_reply_t reply;
  } cmd_row_t;

  cmd_row_t directed_rows[12];

  // config settings per random phase: heap bytes, header bytes
  int unsigned phase_heap[8];
  int unsigned phase_hdr[8];

  initial begin
    alloc_reply_t none;
    none = '0;
    directed_rows = '{
      '{CMD_ALLOC, 16'd0,     16'd0,     1,  1, '{ST_BAD,     16'd0}},   // zero request
      '{CMD_FREE,  16'hFFFF,  16'd0,     1,  1, '{ST_BAD,     16'd0}},   // null free
      '{CMD_FREE,  16'd0,     16'd1234,  1,  1, '{ST_INVALID, 16'd0}},   // unknown pointer
      '{CMD_ALLOC, 16'd1,     16'hFFFF,  1,  1, '{ST_OK,      16'd8}},   // first block at 0
      '{CMD_ALLOC, 16'hFFFF,  16'd0,     1,  1, '{ST_NOSPACE, 16'd0}},   // largest request
      '{CMD_ALLOC, 16'd8,     16'd0,     1,  1, '{ST_OK,      16'd24}},
      '{CMD_FREE,  16'd0,     16'd8,     1,  1, '{ST_OK,      16'd0}},
      '{CMD_FREE,  16'd0,     16'd8,     1,  1, '{ST_INVALID, 16'd0}},   // double free
      '{CMD_ALLOC, 16'd1000,  16'd0,     1,  0, none},                   // hole too small
      '{CMD_ALLOC, 16'd1,     16'd0,     15, 0, none},                   // fill live table
      '{CMD_ALLOC, 16'd1,     16'd0,     1,  1, '{ST_FULL,    16'd0}},   // live table full
      '{CMD_FREE,  16'd0,     16'd24,    1,  0, none}
    };
    phase_heap = '{32'h10000, 1, 0, 200, 4096, 1024, 512, 32'h10000};
    phase_hdr  = '{0, 64, 8, 3, 16, 8, 0, 64};

    rst_ni = 1'b0;
    start <= 1'b0;
    cmd_i <= CMD_ALLOC;
    request_size_i <= '0;
    block_address_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_HEAP_SIZE;
    cfg_data_i <= '0;
    mismatches = 0;
    idle_on = 1'b1;
    hdr_bytes = HEADER_RESET;
    heap_rebuild(HEAP_RESET);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      repeat (directed_rows[r].reps)
        issue(directed_rows[r].c, directed_rows[r].req, directed_rows[r].uaddr,
              directed_rows[r].typed, directed_rows[r].reply);

    // random phases; odd phases also swap the header size mid-way with
    // blocks still live, which moves the addresses a free must present
    for (int p = 0; p < 8; p++) begin
      reg_write(REG_HEAP_SIZE, phase_heap[p]);
      reg_write(REG_HEADER, phase_hdr[p]);
      idle_on = (p < 6);
      for (int n = 0; n < 160; n++) begin
        if (n == 80 && p[0]) reg_write(REG_HEADER, $urandom_range(0, 64));
        random_item();
      end
    end

    drain();
    $display("covered: %0d ok, %0d bad/null, %0d no space, %0d invalid, %0d table full",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    $display("over 8 heap/header settings incl. 0, 1 and 64K heaps and 0/64 byte headers");
    if (mismatches == 0) $display("first_fit_heap_allocator_test: PASS");
    else $display("first_fit_heap_allocator_test: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: one strobe per item, compared against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result st=%0d addr=%0d", $time, status_o,
                 result_address_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o <= ST_FULL) status_seen[status_o]++;
        if (status_o !== want.st) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
        end
        if (result_address_o !== want.addr) begin
          mismatches++;
          $display("%0t: address expected %0d actual %0d", $time, want.addr,
                   result_address_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_replies.size());
      $display("first_fit_heap_allocator_test: FAIL");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_test.sv
